>>> design/ior_pkg.sv
// shared types and constants for the image orientation remapper
// no dependencies; imported by ior_ctrl, ior_datapath, image_orientation_remap and the testbench
`default_nettype none

package ior_pkg;

	localparam int COLS_MAX    = 64;
	localparam int ROWS_MAX    = 64;
	localparam int STORE_DEPTH = COLS_MAX * ROWS_MAX;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = 13;
	localparam int DIM_W       = 7;
	localparam int COORD_W     = $clog2((COLS_MAX > ROWS_MAX) ? COLS_MAX : ROWS_MAX);
	localparam int PIX_W       = 32;
	localparam int CFG_ADDR_W  = 2;
	localparam int DIV_CNT_W   = $clog2(CNT_W);
	localparam int OUT_DATA_W  = ((PIX_W + DIM_W + 7) / 8) * 8;

	localparam logic [CFG_ADDR_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_ORIENT = 2'd2;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_PULL = 1'b1;

	typedef enum logic [2:0] {
		OR_IDENTITY,
		OR_FLIP_H,
		OR_ROT180,
		OR_FLIP_V,
		OR_TRANSPOSE,
		OR_ROT270,
		OR_TRANSVERSE,
		OR_ROT90
	} orient_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_READ,
		ST_OUT,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic load_acc;
		logic pull_acc;
		logic div_start;
		logic div_step;
		logic mem_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pull_hit;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

>>> design/ior_ctrl.sv
// controller fsm of the orientation remapper: input handshake and sequencing
// depends on ior_pkg; drives the command struct of ior_datapath
`default_nettype none

module ior_ctrl import ior_pkg::*; (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     s_tvalid,
	input  wire     s_tuser,
	output logic    s_tready,
	input  wire     cfg_we,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   dirty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dirty_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// coordinates must be rebuilt from read_count after any register change
			if (cfg_we) begin
				dirty_q <= 1'b1;
			end else if (cmd.div_step && status.div_last) begin
				dirty_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (dirty_q) begin
					state_d = ST_DIV;
				end else if (cmd.pull_acc && status.pull_hit) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_READ;
			ST_READ: state_d = ST_OUT;
			ST_OUT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				// a write during the division restarts it with the new sizes
				if (cfg_we || status.div_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = (state_q == ST_IDLE) && !dirty_q && !cfg_we;
		cmd           = '0;
		cmd.load_acc  = s_tready && s_tvalid && (s_tuser == MODE_LOAD);
		cmd.pull_acc  = s_tready && s_tvalid && (s_tuser == MODE_PULL);
		cmd.div_start = (state_q == ST_IDLE) && dirty_q;
		cmd.div_step  = (state_q == ST_DIV);
		cmd.mem_rd    = (state_q == ST_READ);
		cmd.out_load  = (state_q == ST_OUT) && status.out_free;
	end

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input ready while fsm busy");

	a_read_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_OUT))
		else $error("store read not followed by output stage");

endmodule

`default_nettype wire

>>> design/ior_datapath.sv
// datapath of the orientation remapper: config registers, counters, coordinate
// divider, address pipeline, frame store and output register; depends on ior_pkg
`default_nettype none

module ior_datapath import ior_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  wire  [PIX_W-1:0]      pixel_in,
	input  wire                   cfg_we,
	input  wire  [CFG_ADDR_W-1:0] cfg_addr,
	input  wire  [DIM_W-1:0]      cfg_wdata,
	input  wire                   out_ready,
	output logic                  out_valid,
	output logic [PIX_W-1:0]      out_pixel,
	output logic                  out_last,
	output logic [DIM_W-1:0]      out_cols
);

	logic [DIM_W-1:0]   width_q, height_q;
	orient_t            orient_q;
	logic [CNT_W-1:0]   load_cnt_q, read_cnt_q;
	logic [COORD_W-1:0] ox_q;
	logic [CNT_W-1:0]   oy_q;

	logic [DIM_W-1:0]   w_c, h_c, ow_c, wm1_c, hm1_c;
	logic [CNT_W-1:0]   total_c;
	logic               full_c, done_c, restart_c, last_c;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(COLS_MAX);
			height_q <= DIM_W'(ROWS_MAX);
			orient_q <= OR_IDENTITY;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_WIDTH:  width_q  <= cfg_wdata;
				REG_HEIGHT: height_q <= cfg_wdata;
				REG_ORIENT: orient_q <= orient_t'(cfg_wdata[2:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_c = DIM_W'(1);
		end else if (width_q > DIM_W'(COLS_MAX)) begin
			w_c = DIM_W'(COLS_MAX);
		end else begin
			w_c = width_q;
		end
		if (height_q == '0) begin
			h_c = DIM_W'(1);
		end else if (height_q > DIM_W'(ROWS_MAX)) begin
			h_c = DIM_W'(ROWS_MAX);
		end else begin
			h_c = height_q;
		end
	end

	// transposing codes have the top bit set
	assign ow_c      = orient_q[2] ? h_c : w_c;
	assign wm1_c     = w_c - DIM_W'(1);
	assign hm1_c     = h_c - DIM_W'(1);
	assign total_c   = CNT_W'(w_c) * CNT_W'(h_c);
	assign full_c    = (load_cnt_q >= total_c);
	assign done_c    = (read_cnt_q >= total_c);
	assign restart_c = full_c && done_c;
	assign last_c    = (read_cnt_q == (total_c - CNT_W'(1)));

	// restoring divider: read_count / ow -> (oy, ox), one quotient bit per step
	logic [CNT_W-1:0]     dq_q, dq_next;
	logic [COORD_W-1:0]   rem_q, rem_next;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [COORD_W:0]     rem_shift, rem_sub;
	logic                 ge_c;

	assign rem_shift = {rem_q, dq_q[CNT_W-1]};
	assign ge_c      = (rem_shift >= ow_c);
	assign rem_sub   = rem_shift - ow_c;
	assign rem_next  = ge_c ? rem_sub[COORD_W-1:0] : rem_shift[COORD_W-1:0];
	assign dq_next   = {dq_q[CNT_W-2:0], ge_c};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q  <= read_cnt_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= dq_next;
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
	end

	assign status.div_last = (div_cnt_q == DIV_CNT_W'(CNT_W - 1));
	assign status.pull_hit = full_c && !done_c;

	// counters and output coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			read_cnt_q <= '0;
			ox_q       <= '0;
			oy_q       <= '0;
		end else if (cmd.load_acc) begin
			if (restart_c) begin
				load_cnt_q <= CNT_W'(1);
				read_cnt_q <= '0;
				ox_q       <= '0;
				oy_q       <= '0;
			end else if (!full_c) begin
				load_cnt_q <= load_cnt_q + CNT_W'(1);
			end
		end else if (cmd.pull_acc && status.pull_hit) begin
			read_cnt_q <= read_cnt_q + CNT_W'(1);
			if ((DIM_W'(ox_q) + DIM_W'(1)) == ow_c) begin
				ox_q <= '0;
				oy_q <= oy_q + CNT_W'(1);
			end else begin
				ox_q <= ox_q + COORD_W'(1);
			end
		end else if (cmd.div_step && status.div_last) begin
			ox_q <= rem_next;
			oy_q <= dq_next;
		end
	end

	// source row and column of the current output pixel
	logic [DIM_W-1:0]   ox_w, oy_w, wx_c, wy_c, hx_c, hy_c;
	logic [COORD_W-1:0] row_c, col_c;

	assign ox_w = DIM_W'(ox_q);
	assign oy_w = DIM_W'(oy_q[COORD_W-1:0]);
	assign wx_c = wm1_c - ox_w;
	assign wy_c = wm1_c - oy_w;
	assign hx_c = hm1_c - ox_w;
	assign hy_c = hm1_c - oy_w;

	always_comb begin
		unique case (orient_q)
			OR_IDENTITY: begin
				row_c = oy_w[COORD_W-1:0];
				col_c = ox_w[COORD_W-1:0];
			end
			OR_FLIP_H: begin
				row_c = oy_w[COORD_W-1:0];
				col_c = wx_c[COORD_W-1:0];
			end
			OR_ROT180: begin
				row_c = hy_c[COORD_W-1:0];
				col_c = wx_c[COORD_W-1:0];
			end
			OR_FLIP_V: begin
				row_c = hy_c[COORD_W-1:0];
				col_c = ox_w[COORD_W-1:0];
			end
			OR_TRANSPOSE: begin
				row_c = ox_w[COORD_W-1:0];
				col_c = oy_w[COORD_W-1:0];
			end
			OR_ROT270: begin
				row_c = hx_c[COORD_W-1:0];
				col_c = oy_w[COORD_W-1:0];
			end
			OR_TRANSVERSE: begin
				row_c = hx_c[COORD_W-1:0];
				col_c = wy_c[COORD_W-1:0];
			end
			OR_ROT90: begin
				row_c = ox_w[COORD_W-1:0];
				col_c = wy_c[COORD_W-1:0];
			end
			default: begin
				row_c = oy_w[COORD_W-1:0];
				col_c = ox_w[COORD_W-1:0];
			end
		endcase
	end

	// address pipeline: capture, multiply, add and read
	logic [COORD_W-1:0] row_s1, col_s1, col_s2;
	logic [CNT_W-1:0]   prod_s2;
	logic [ADDR_W-1:0]  rd_addr_c, wr_addr_c;
	logic [PIX_W-1:0]   rdata_s3;
	logic               last_q;
	logic [DIM_W-1:0]   ow_q;
	logic               store_we_c;

	always_ff @(posedge clk) begin
		if (cmd.pull_acc && status.pull_hit) begin
			row_s1 <= row_c;
			col_s1 <= col_c;
			last_q <= last_c;
			ow_q   <= ow_c;
		end
		prod_s2 <= CNT_W'(row_s1) * CNT_W'(w_c);
		col_s2  <= col_s1;
	end

	assign rd_addr_c  = ADDR_W'(prod_s2 + CNT_W'(col_s2));
	assign wr_addr_c  = restart_c ? '0 : load_cnt_q[ADDR_W-1:0];
	assign store_we_c = cmd.load_acc && (restart_c || !full_c);

	logic [PIX_W-1:0] store_mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (store_we_c) begin
			store_mem[wr_addr_c] <= pixel_in;
		end
		if (cmd.mem_rd) begin
			rdata_s3 <= store_mem[rd_addr_c];
		end
	end

	// output register
	logic out_valid_q;

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pixel <= rdata_s3;
			out_last  <= last_q;
			out_cols  <= ow_q;
		end
	end

	a_read_le_load: assert property (@(posedge clk) disable iff (!arst_n)
		read_cnt_q <= load_cnt_q)
		else $error("more pixels read than loaded");

	a_pull_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pull_acc && status.pull_hit) |=> (read_cnt_q == ($past(read_cnt_q) + CNT_W'(1))))
		else $error("read count did not advance on a pull");

endmodule

`default_nettype wire

>>> design/image_orientation_remap.sv
// a pull beat's pixel passes the capture, multiply and store read registers to the output
// register, which loads once it is empty or m_tready takes its beat; one load beat per cycle
// while s_tready is high; no new beat is taken until a pull beat has reached the output register
// a register write holds s_tready low in its own cycle and through the start cycle and the
// divider steps after it; a write during the division restarts it; reset sets the config
// to its defaults, clears counters and the fsm; the frame store holds unknown data until loaded
`default_nettype none

module image_orientation_remap import ior_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	input  wire  [PIX_W-1:0]      s_tdata,   // pixel_in [31:0]
	input  wire                   s_tuser,   // mode [0]
	output logic                  m_tvalid,
	input  wire                   m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // pixel_out [31:0], output width [38:32], zero [39]
	output logic                  m_tlast,
	input  wire                   cfg_we,
	input  wire  [CFG_ADDR_W-1:0] cfg_addr,
	input  wire  [DIM_W-1:0]      cfg_wdata
);

	cmd_t             cmd;
	status_t          status;
	logic [PIX_W-1:0] out_pixel;
	logic [DIM_W-1:0] out_cols;

	ior_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.cfg_we   (cfg_we),
		.status   (status),
		.cmd      (cmd)
	);

	ior_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pixel_in  (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_pixel (out_pixel),
		.out_last  (m_tlast),
		.out_cols  (out_cols)
	);

	assign m_tdata = {{(OUT_DATA_W - PIX_W - DIM_W){1'b0}}, out_cols, out_pixel};

endmodule

`default_nettype wire

>>> tb/image_orientation_remap_tb.sv
// testbench for image_orientation_remap: loads frames, pulls the reoriented pixels and
// checks each output beat against a behavioral remap of the frame store
// depends on ior_pkg and the image_orientation_remap rtl
`timescale 1ns / 1ps

import ior_pkg::*;

typedef struct {
	logic [PIX_W-1:0] pixel;
	logic             last;
	logic [DIM_W-1:0] width;
} remap_beat_t;

class remap_scoreboard;
	logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
	int unsigned      loaded;
	int unsigned      pulled;
	logic [DIM_W-1:0] reg_w;
	logic [DIM_W-1:0] reg_h;
	orient_t          reg_or;
	remap_beat_t      remapped_q[$];
	int unsigned      errors;

	function new();
		loaded = 0;
		pulled = 0;
		reg_w = DIM_W'(COLS_MAX);
		reg_h = DIM_W'(ROWS_MAX);
		reg_or = OR_IDENTITY;
		errors = 0;
	endfunction

	function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [DIM_W-1:0] value);
		case (idx)
			REG_WIDTH: reg_w = value;
			REG_HEIGHT: reg_h = value;
			REG_ORIENT: reg_or = orient_t'(value[2:0]);
			default: ;
		endcase
	endfunction

	// zero counts as one, oversize counts as the maximum
	function int unsigned dim(logic [DIM_W-1:0] value, int unsigned maxv);
		if (value == 0)
			return 1;
		if (value > maxv)
			return maxv;
		return value;
	endfunction

	function int unsigned frame_size();
		return dim(reg_w, COLS_MAX) * dim(reg_h, ROWS_MAX);
	endfunction

	function bit frame_loaded();
		return loaded >= frame_size();
	endfunction

	function bit frame_read();
		return pulled >= frame_size();
	endfunction

	// source index of output pixel (ox, oy) for a w by h source
	function int unsigned src_index(int unsigned ox, int unsigned oy, int unsigned w,
			int unsigned h);
		case (reg_or)
			OR_FLIP_H: return oy * w + (w - 1 - ox);
			OR_ROT180: return (h - 1 - oy) * w + (w - 1 - ox);
			OR_FLIP_V: return (h - 1 - oy) * w + ox;
			OR_TRANSPOSE: return ox * w + oy;
			OR_ROT270: return (h - 1 - ox) * w + oy;
			OR_TRANSVERSE: return (h - 1 - ox) * w + (w - 1 - oy);
			OR_ROT90: return ox * w + (w - 1 - oy);
			default: return oy * w + ox;
		endcase
	endfunction

	// returns 1 when the beat stored a pixel or produced one
	function bit note_input(logic mode, logic [PIX_W-1:0] pixel);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned ow;
		remap_beat_t beat;
		w = dim(reg_w, COLS_MAX);
		h = dim(reg_h, ROWS_MAX);
		total = w * h;
		ow = reg_or[2] ? h : w;
		if (mode == MODE_LOAD) begin
			if (loaded >= total && pulled >= total) begin
				loaded = 0;
				pulled = 0;
			end
			if (loaded < total) begin
				frame_mem[loaded % STORE_DEPTH] = pixel;
				loaded++;
				return 1;
			end
			return 0;
		end
		if (loaded < total || pulled >= total)
			return 0;
		beat.pixel = frame_mem[src_index(pulled % ow, pulled / ow, w, h) % STORE_DEPTH];
		beat.last = (pulled == total - 1);
		beat.width = DIM_W'(ow);
		remapped_q.push_back(beat);
		pulled++;
		return 1;
	endfunction

	function void check_output(logic [PIX_W-1:0] pixel, logic last, logic [DIM_W-1:0] width);
		remap_beat_t exp_beat;
		if (remapped_q.size() == 0) begin
			$error("unexpected output beat: pixel_out %h last %b output width %0d",
				pixel, last, width);
			errors++;
			return;
		end
		exp_beat = remapped_q.pop_front();
		if (pixel !== exp_beat.pixel) begin
			$error("pixel_out: expected %h, got %h", exp_beat.pixel, pixel);
			errors++;
		end
		if (last !== exp_beat.last) begin
			$error("last: expected %b, got %b", exp_beat.last, last);
			errors++;
		end
		if (width !== exp_beat.width) begin
			$error("output width: expected %0d, got %0d", exp_beat.width, width);
			errors++;
		end
	endfunction
endclass

module image_orientation_remap_tb;
	localparam int SETTLE_CYCLES = 24;
	localparam int LIMIT_CYCLES  = 800000;
	localparam int TARGET_BEATS  = 1850;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [DIM_W-1:0]      cfg_wdata = '0;

	remap_scoreboard sb = new();
	int unsigned     src_gap_pct = 0;
	int unsigned     sink_stall_pct = 0;
	int unsigned     working_beats = 0;
	int unsigned     cycle_count = 0;

	image_orientation_remap dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("image_orientation_remap_tb: errors");
			$finish;
		end
	end

	// output side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_output(m_tdata[PIX_W-1:0], m_tlast, m_tdata[PIX_W+DIM_W-1:PIX_W]);
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	task automatic push_source_beat(input logic mode, input logic [PIX_W-1:0] pixel);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= pixel;
		do @(posedge clk); while (!s_tready);
		if (sb.note_input(mode, pixel))
			working_beats++;
	endtask

	// registers change only once every pulled pixel is back and the block has settled
	task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic [DIM_W-1:0] orient_word);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.remapped_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		sb.write_reg(REG_WIDTH, w);
		cfg_addr <= REG_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		sb.write_reg(REG_HEIGHT, h);
		cfg_addr <= REG_ORIENT;
		cfg_wdata <= orient_word;
		@(posedge clk);
		sb.write_reg(REG_ORIENT, orient_word);
		cfg_we <= 1'b0;
	endtask

	// one frame from whatever state the block is in, with some noise or a broken end
	task automatic run_frame();
		int unsigned style;
		style = $urandom_range(9);
		if (style == 0) begin
			repeat ($urandom_range(1, sb.frame_size())) push_source_beat(MODE_LOAD, $urandom());
		end else if (style == 1) begin
			repeat ($urandom_range(4, 24)) push_source_beat(1'($urandom_range(1)), $urandom());
		end else begin
			if (sb.frame_loaded() && sb.frame_read())
				push_source_beat(MODE_LOAD, $urandom());
			while (!sb.frame_loaded()) begin
				if ($urandom_range(15) == 0)
					push_source_beat(MODE_PULL, $urandom());
				push_source_beat(MODE_LOAD, $urandom());
			end
			while (!sb.frame_read()) begin
				if ($urandom_range(15) == 0)
					push_source_beat(MODE_LOAD, $urandom());
				push_source_beat(MODE_PULL, $urandom());
			end
			if ($urandom_range(7) == 0)
				push_source_beat(MODE_PULL, $urandom());
		end
	endtask

	initial begin
		int unsigned      phase_no;
		int unsigned      shape;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [DIM_W-1:0] orient_word;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 3x2 rotated, pulls too early and too late, dropped load
		set_frame(7'd3, 7'd2, DIM_W'(OR_ROT90));
		push_source_beat(MODE_PULL, 32'hFFFF_FFFF);
		push_source_beat(MODE_LOAD, 32'h0000_0000);
		push_source_beat(MODE_LOAD, 32'hFFFF_FFFF);
		push_source_beat(MODE_PULL, 32'h0000_0000);
		push_source_beat(MODE_LOAD, 32'hA5A5_A5A5);
		push_source_beat(MODE_LOAD, 32'h5A5A_5A5A);
		push_source_beat(MODE_LOAD, 32'h0000_0001);
		push_source_beat(MODE_LOAD, 32'h8000_0000);
		push_source_beat(MODE_LOAD, 32'h1234_5678);
		repeat (6) push_source_beat(MODE_PULL, $urandom());
		push_source_beat(MODE_PULL, $urandom());
		// a load after readout opens a new frame, then the frame shrinks under it
		push_source_beat(MODE_LOAD, 32'hC3C3_3C3C);
		push_source_beat(MODE_LOAD, 32'h7FFF_FFFE);
		set_frame(7'd1, 7'd2, DIM_W'(OR_FLIP_V));
		repeat (2) push_source_beat(MODE_PULL, $urandom());

		phase_no = 0;
		while (working_beats < TARGET_BEATS) begin
			case (phase_no % 4)
				0: begin src_gap_pct = 0; sink_stall_pct = 0; end
				1: begin src_gap_pct = 73; sink_stall_pct = 0; end
				2: begin src_gap_pct = 0; sink_stall_pct = 73; end
				default: begin src_gap_pct = 36; sink_stall_pct = 36; end
			endcase
			shape = $urandom_range(9);
			case (shape)
				0: begin
					w = (($urandom_range(1) == 0) ? 7'd64 : 7'($urandom_range(65, 127)));
					h = 7'($urandom_range(1, 2));
				end
				1: begin
					w = 7'($urandom_range(1, 2));
					h = (($urandom_range(1) == 0) ? 7'd64 : 7'($urandom_range(65, 127)));
				end
				2: begin
					w = 7'($urandom_range(0, 1));
					h = 7'($urandom_range(0, 4));
				end
				default: begin
					w = 7'($urandom_range(1, 8));
					h = 7'($urandom_range(1, 8));
				end
			endcase
			orient_word = 7'($urandom_range(7));
			// upper bits of the orientation word are don't-care
			if ($urandom_range(3) == 0)
				orient_word[DIM_W-1:3] = 4'($urandom_range(15));
			set_frame(w, h, orient_word);
			repeat ($urandom_range(1, 3)) run_frame();
			phase_no++;
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.remapped_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("image_orientation_remap_tb: clean");
		else
			$display("image_orientation_remap_tb: errors");
		$finish;
	end
endmodule
